// ----- rtl/core/flt32_pkg.sv -----
// Shared types, constants and the end-around-carry adder for the Fletcher-32 core.
`default_nettype none
package flt32_pkg;

  localparam logic [15:0] SumInit = 16'hFFFF;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } word_t;

  function automatic logic [15:0] oc_add(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, x} + {1'b0, y};
    f = {1'b0, s[15:0]} + {16'b0, s[16]};
    return f[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/flt32_fifo.sv -----
// Small synchronous show-ahead queue built from flip-flops.
`default_nettype none
module flt32_fifo #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  a_push_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> !empty_o)
    else $error("queue empty after a lone push");

  a_pop_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push && cnt_q == CntW'(1) |=> empty_o)
    else $error("queue not empty after popping its only entry");

endmodule
`default_nettype wire

// ----- rtl/core/flt32_front.sv -----
// Front end: pairs incoming bytes big-endian into 16-bit words.
`default_nettype none
module flt32_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         byte_valid_i,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_byte_i,
  output logic              word_push_o,
  output flt32_pkg::word_t  word_o
);
  import flt32_pkg::*;

  logic [7:0] hold_q, hold_d;
  logic       half_q, half_d;

  always_comb begin
    hold_d      = hold_q;
    half_d      = half_q;
    word_push_o = 1'b0;
    word_o.word = {data_byte_i, 8'h00};
    word_o.last = last_byte_i;
    if (byte_valid_i) begin
      if (half_q) begin
        word_push_o = 1'b1;
        word_o.word = {hold_q, data_byte_i};
        half_d      = 1'b0;
        hold_d      = 8'h00;
      end else if (last_byte_i) begin
        word_push_o = 1'b1;
      end else begin
        hold_d = data_byte_i;
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 8'h00;
      half_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      half_q <= half_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/flt32_back.sv -----
// Back end: accumulates Fletcher sums A and B and issues the checksum on the last word.
`default_nettype none
module flt32_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         word_empty_i,
  input  wire flt32_pkg::word_t word_i,
  output logic              word_pop_o,
  input  wire logic         res_full_i,
  output logic              res_push_o,
  output logic [31:0]       res_o
);
  import flt32_pkg::*;

  logic [15:0] sum_a_q, sum_a_d;
  logic [15:0] sum_b_q, sum_b_d;
  logic [15:0] a_new, b_new;

  assign a_new      = oc_add(sum_a_q, word_i.word);
  assign b_new      = oc_add(sum_b_q, a_new);
  assign word_pop_o = !word_empty_i && (!word_i.last || !res_full_i);
  assign res_push_o = word_pop_o && word_i.last;
  assign res_o      = {b_new, a_new};

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (word_pop_o) begin
      if (word_i.last) begin
        sum_a_d = SumInit;
        sum_b_d = SumInit;
      end else begin
        sum_a_d = a_new;
        sum_b_d = b_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= SumInit;
      sum_b_q <= SumInit;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_pop_o && word_i.last |=> sum_a_q == SumInit && sum_b_q == SumInit)
    else $error("sums did not restart after the last word");

  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_a_q != 16'h0000 && sum_b_q != 16'h0000)
    else $error("running sum reached zero");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("checksum issued into a full result queue");

endmodule
`default_nettype wire

// ----- rtl/core/fletcher32_byte_stream_core.sv -----
// Top level of the Fletcher-32 byte-stream checksum core.
//
// The input side behaves as a queue: a byte with its last flag is written
// in a transaction when push is high and full is low. Bytes are paired
// big-endian into 16-bit words; an odd final byte gets a zero low byte.
// The output side behaves as a queue too: while empty is low, checksum_o
// holds the oldest result ({B, A}), and pop takes it in a transaction.
// One byte is accepted per cycle, sustained, as long as results are taken.
// A checksum passes through the word queue and then the result queue after its
// last byte is accepted; the sums are added as the word leaves the word queue.
// When the result queue is full, the back end holds the last word of a
// message, the word queue fills, and full rises to stall the sender.
// Reset empties both queues and returns both sums to 0xFFFF.
`default_nettype none
module fletcher32_byte_stream_core #(
  parameter int unsigned WORD_Q_DEPTH = 2,
  parameter int unsigned RES_Q_DEPTH  = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      checksum_o
);
  import flt32_pkg::*;

  logic  byte_valid;
  logic  word_push, word_full, word_pop, word_empty;
  word_t front_word, back_word;
  logic  res_push, res_full;
  logic [31:0] res_data;

  assign full       = word_full;
  assign byte_valid = push && !word_full;

  flt32_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .word_push_o (word_push),
    .word_o      (front_word)
  );

  flt32_fifo #(
    .Width($bits(word_t)),
    .Depth(WORD_Q_DEPTH)
  ) u_word_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (word_push),
    .data_i (front_word),
    .full_o (word_full),
    .pop_i  (word_pop),
    .data_o (back_word),
    .empty_o(word_empty)
  );

  flt32_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_empty_i(word_empty),
    .word_i      (back_word),
    .word_pop_o  (word_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  flt32_fifo #(
    .Width(32),
    .Depth(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (checksum_o),
    .empty_o(empty)
  );

endmodule
`default_nettype wire
